### rtl/imrot_pkg.sv
// Shared types and constants of the image rotation block.
package imrot_pkg;

  // Input beat commands (carried on in_tuser)
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_COEFF    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_COEFF    = 2'd3;

  // Field widths
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIM_W      = 7;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned PIX_W      = 24;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  // Datapath widths: half-pixel offsets, Q.15 products and sums, source coordinate
  localparam int unsigned OFS_W   = POS_W + 2;
  localparam int unsigned PROD_W  = OFS_W + COEF_W;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned FRAC_W  = 15;
  localparam int unsigned COORD_W = SUM_W - FRAC_W;

  // Reset values of the registers
  localparam logic [DIM_W-1:0]         RST_IMAGE_WIDTH  = 7'd64;
  localparam logic [DIM_W-1:0]         RST_IMAGE_HEIGHT = 7'd64;
  localparam logic signed [COEF_W-1:0] RST_COS_COEFF    = 16'sd16384;
  localparam logic signed [COEF_W-1:0] RST_SIN_COEFF    = 16'sd0;

  // Pixel store access strobes
  typedef struct packed {
    logic wr;
    logic rd;
  } imrot_mem_ctrl_t;

endpackage

### rtl/imrot_store.sv
// Source pixel store: one write or one registered read per cycle.
module imrot_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                           clk,
  input  imrot_pkg::imrot_mem_ctrl_t     ctrl,
  input  logic [ADDR_W-1:0]              addr,
  input  logic [imrot_pkg::PIX_W-1:0]    wdata,
  output logic [imrot_pkg::PIX_W-1:0]    rdata
);
  import imrot_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  // Write a loaded pixel, register the read word
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctrl.rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/image_rotate_nearest_unit.sv
// Image rotation by inverse mapping with nearest-pixel sampling, five-stage pipeline.
// A read beat's result is on out_tvalid once the beat has passed the stage 1 to stage 5 registers.
// Throughput: one beat per cycle unless the output stalls; each stage holds its beat only while the next one is full.
// Loads write the pixel store in the last stage and drop out there with no result.
// Reset (rst_n low at a clock edge) empties the pipeline and restores the registers.
// The pixel store is not cleared; its entries hold garbage until loaded.
module image_rotate_nearest_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [5:0] column, [11:6] row, [35:12] pixel_in, [39:36] zero
  input  logic [imrot_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] command
  input  logic                               in_tuser,
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [23:0] pixel_out
  output logic [imrot_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [0] inside_res
  output logic                               out_tuser,
  // Configuration
  input  logic                               cfg_wen,
  input  logic [imrot_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [imrot_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import imrot_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  // Configuration registers
  logic [DIM_W-1:0]         image_width_r;
  logic [DIM_W-1:0]         image_height_r;
  logic signed [COEF_W-1:0] cos_coeff_r;
  logic signed [COEF_W-1:0] sin_coeff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= RST_IMAGE_WIDTH;
      image_height_r <= RST_IMAGE_HEIGHT;
      cos_coeff_r    <= RST_COS_COEFF;
      sin_coeff_r    <= RST_SIN_COEFF;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[DIM_W-1:0];
        REG_COS_COEFF:    cos_coeff_r    <= cfg_wdata[COEF_W-1:0];
        REG_SIN_COEFF:    sin_coeff_r    <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective size, limited to the store
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  always_comb begin
    w_eff = (int'(image_width_r) < MAX_WIDTH) ? image_width_r : DIM_W'(MAX_WIDTH);
    h_eff = (int'(image_height_r) < MAX_HEIGHT) ? image_height_r : DIM_W'(MAX_HEIGHT);
  end

  // Stage enables: a stage loads when empty or when the next stage loads
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || out_tready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  logic in_beat;
  assign in_beat = in_tvalid && in_tready;

  // Unpack the input beat
  logic [POS_W-1:0] in_col;
  logic [POS_W-1:0] in_row;
  logic [PIX_W-1:0] in_pix;
  assign in_col = in_tdata[POS_W-1:0];
  assign in_row = in_tdata[2*POS_W-1:POS_W];
  assign in_pix = in_tdata[2*POS_W+PIX_W-1:2*POS_W];

  // Stage 1: offsets from the center in half pixels
  logic                    cmd1_r;
  logic [POS_W-1:0]        col1_r, row1_r;
  logic [PIX_W-1:0]        pix1_r;
  logic signed [OFS_W-1:0] dx1_r, dy1_r;
  logic signed [OFS_W-1:0] dx_nxt, dy_nxt;

  always_comb begin
    dx_nxt = $signed({1'b0, in_col, 1'b0}) - $signed({1'b0, w_eff});
    dy_nxt = $signed({1'b0, in_row, 1'b0}) - $signed({1'b0, h_eff});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1_r <= in_tuser;
      col1_r <= in_col;
      row1_r <= in_row;
      pix1_r <= in_pix;
      dx1_r  <= dx_nxt;
      dy1_r  <= dy_nxt;
    end
  end

  // Stage 2: the four rotation products
  logic                     cmd2_r;
  logic [POS_W-1:0]         col2_r, row2_r;
  logic [PIX_W-1:0]         pix2_r;
  logic signed [PROD_W-1:0] dys2_r, dxc2_r, dyc2_r, dxs2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      cmd2_r <= cmd1_r;
      col2_r <= col1_r;
      row2_r <= row1_r;
      pix2_r <= pix1_r;
      dys2_r <= dy1_r * sin_coeff_r;
      dxc2_r <= dx1_r * cos_coeff_r;
      dyc2_r <= dy1_r * cos_coeff_r;
      dxs2_r <= dx1_r * sin_coeff_r;
    end
  end

  // Stage 3: source position in Q.15
  logic                    cmd3_r;
  logic [POS_W-1:0]        col3_r, row3_r;
  logic [PIX_W-1:0]        pix3_r;
  logic signed [SUM_W-1:0] numx3_r, numy3_r;
  logic signed [SUM_W-1:0] ctrx, ctry, numx_nxt, numy_nxt;

  always_comb begin
    ctrx = $signed({{(SUM_W-DIM_W-14){1'b0}}, w_eff, 14'b0});
    ctry = $signed({{(SUM_W-DIM_W-14){1'b0}}, h_eff, 14'b0});
    numx_nxt = ctrx + SUM_W'(dys2_r) + SUM_W'(dxc2_r);
    numy_nxt = ctry + SUM_W'(dyc2_r) - SUM_W'(dxs2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      cmd3_r  <= cmd2_r;
      col3_r  <= col2_r;
      row3_r  <= row2_r;
      pix3_r  <= pix2_r;
      numx3_r <= numx_nxt;
      numy3_r <= numy_nxt;
    end
  end

  // Stage 4: truncate toward zero, test the bounds, form the store address
  logic                      cmd4_r;
  logic                      ok4_r;
  logic [ADDR_W-1:0]         addr4_r;
  logic [PIX_W-1:0]          pix4_r;
  logic signed [SUM_W-1:0]   biasx, biasy;
  logic signed [COORD_W-1:0] sx, sy;
  logic                      inside_nxt, load_ok;
  logic [DIM_W-1:0]          ax, ay;
  logic                      ok_nxt;
  logic [ADDR_W-1:0]         addr_nxt;

  always_comb begin
    biasx = numx3_r + (numx3_r[SUM_W-1] ? SUM_W'(32767) : SUM_W'(0));
    biasy = numy3_r + (numy3_r[SUM_W-1] ? SUM_W'(32767) : SUM_W'(0));
    sx = biasx[SUM_W-1:FRAC_W];
    sy = biasy[SUM_W-1:FRAC_W];
    inside_nxt = !sx[COORD_W-1] && !sy[COORD_W-1]
                 && (sx[COORD_W-2:0] < (COORD_W-1)'(w_eff))
                 && (sy[COORD_W-2:0] < (COORD_W-1)'(h_eff));
    load_ok = (int'(col3_r) < MAX_WIDTH) && (int'(row3_r) < MAX_HEIGHT);
    if (cmd3_r == CMD_READ) begin
      ax     = sx[DIM_W-1:0];
      ay     = sy[DIM_W-1:0];
      ok_nxt = inside_nxt;
    end else begin
      ax     = {1'b0, col3_r};
      ay     = {1'b0, row3_r};
      ok_nxt = load_ok;
    end
    addr_nxt = ADDR_W'(ay) * ADDR_W'(MAX_WIDTH) + ADDR_W'(ax);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      cmd4_r  <= cmd3_r;
      ok4_r   <= ok_nxt;
      addr4_r <= addr_nxt;
      pix4_r  <= pix3_r;
    end
  end

  // Stage 5: store access; loads write and drop, reads fill the output register
  imrot_mem_ctrl_t  mem_ctrl;
  logic [PIX_W-1:0] mem_rdata;
  logic             inside5_r;

  always_comb begin
    mem_ctrl.wr = en5 && v4_r && (cmd4_r == CMD_LOAD) && ok4_r;
    mem_ctrl.rd = en5 && v4_r && (cmd4_r == CMD_READ);
  end

  imrot_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .ctrl  (mem_ctrl),
    .addr  (addr4_r),
    .wdata (pix4_r),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= v4_r && (cmd4_r == CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      inside5_r <= ok4_r;
    end
  end

  // Drive the result beat; an outside position reads as zero
  assign out_tvalid = v5_r;
  assign out_tdata  = inside5_r ? mem_rdata : '0;
  assign out_tuser  = inside5_r;

  // Input stalls only when the whole pipeline backs up behind the output
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r && v4_r && out_tvalid && !out_tready))
    else $error("input stalled with a bubble in the pipeline");

  // A load leaving stage 4 never produces a result
  a_load_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (en5 && v4_r && cmd4_r == CMD_LOAD) |=> !v5_r)
    else $error("load beat produced a result");

  // A held stage keeps its products
  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !en2) |=> (v2_r && $stable(dys2_r) && $stable(dxc2_r)))
    else $error("stage 2 lost its beat under stall");

  // Every write and every in-bounds read stays inside the store
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_ctrl.wr || (mem_ctrl.rd && ok4_r)) |-> (int'(addr4_r) < DEPTH))
    else $error("store address out of range");

endmodule
